// ===== rtl/vector_magnitude_3d_top_defines.svh =====
// Assertion macros for the vector magnitude block.
// Each expects clk and rst in scope at the point of use.
`ifndef VECTOR_MAGNITUDE_3D_TOP_DEFINES_SVH
`define VECTOR_MAGNITUDE_3D_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define VM3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vm3 check failed");

// Next-cycle implication.
`define VM3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vm3 check failed");

`else

`define VM3_ASSERT_IMP(lbl, ante, cons)
`define VM3_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/vm3_pkg.sv =====
package vm3_pkg;

  // Default sample width in bits (components are taken as two's complement).
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Field and register widths fixed by the interface.
  localparam int FIELD_W = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int COUNT_W = 2;

  // Register index of component_count.
  localparam logic [0:0] REG_COMPONENT_COUNT = 1'b0;

  // component_count codes and reset value.
  localparam logic [COUNT_W-1:0] COUNT_TWO   = 2'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 2'd1;

  // Control that travels with each word through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } meta_t;

endpackage

// ===== rtl/vector_magnitude_3d_top.sv =====
// Euclidean length of up to three signed fixed-point components.
// From acceptance to out_valid a word passes stages 1 to 3, then the root pipeline that
// resolves one result bit per stage. Throughput: one word per cycle unless the output
// word is held; an input skid stage absorbs one word during a stall.
// Reset (rst, synchronous): clears all valid bits and the skid, component_count to 1.
`include "vector_magnitude_3d_top_defines.svh"

module vector_magnitude_3d_top #(
  parameter int SAMPLE_WIDTH = vm3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [vm3_pkg::FIELD_W-1:0] first_component,
  input  logic signed [vm3_pkg::FIELD_W-1:0] second_component,
  input  logic signed [vm3_pkg::FIELD_W-1:0] third_component,
  input  logic                         last_point_in,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vm3_pkg::FIELD_W-1:0]  magnitude,
  output logic                         last_point_out,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vm3_pkg::ADDR_W-1:0]   paddr,
  input  logic [vm3_pkg::DATA_W-1:0]   pwdata,
  output logic [vm3_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int RW = 2 * SAMPLE_WIDTH;

  // Register file
  logic [vm3_pkg::COUNT_W-1:0] component_count;
  logic                        reg_sel;

  assign reg_sel = (paddr[2] == vm3_pkg::REG_COMPONENT_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? vm3_pkg::DATA_W'(component_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_count <= vm3_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      component_count <= pwdata[vm3_pkg::COUNT_W-1:0];
    end
  end

  // Pipeline advances unless the output word is held
  logic adv;
  assign adv = !(out_valid && out_stall);

  // Input skid stage
  logic         skid_valid;
  logic [W-1:0] skid_first, skid_second, skid_third;
  logic         skid_last;
  logic         in_take;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_take) begin
      skid_first  <= first_component[W-1:0];
      skid_second <= second_component[W-1:0];
      skid_third  <= third_component[W-1:0];
      skid_last   <= last_point_in;
    end
  end

  // Source word for stage 1
  logic         src_valid, src_last;
  logic [W-1:0] src_a, src_b, src_c;
  logic         use_b, use_c;

  assign src_valid = skid_valid || in_valid;
  assign src_a     = skid_valid ? skid_first  : first_component[W-1:0];
  assign src_b     = skid_valid ? skid_second : second_component[W-1:0];
  assign src_c     = skid_valid ? skid_third  : third_component[W-1:0];
  assign src_last  = skid_valid ? skid_last   : last_point_in;
  assign use_b     = (component_count == vm3_pkg::COUNT_TWO) ||
                     (component_count == vm3_pkg::COUNT_THREE);
  assign use_c     = (component_count == vm3_pkg::COUNT_THREE);

  // Stage 1: absolute values, unused components zeroed
  logic [W-1:0]   abs_a, abs_b, abs_c;
  vm3_pkg::meta_t meta1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else if (adv) begin
      meta1.valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta1.last <= src_last;
      abs_a      <= src_a[W-1] ? (~src_a + W'(1)) : src_a;
      abs_b      <= !use_b ? '0 : (src_b[W-1] ? (~src_b + W'(1)) : src_b);
      abs_c      <= !use_c ? '0 : (src_c[W-1] ? (~src_c + W'(1)) : src_c);
    end
  end

  // Stage 2: squares
  logic [RW-1:0]  sq_a, sq_b, sq_c;
  logic [RW-1:0]  prod_a, prod_b, prod_c;
  vm3_pkg::meta_t meta2;

  assign prod_a = abs_a * abs_a;
  assign prod_b = abs_b * abs_b;
  assign prod_c = abs_c * abs_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta2.valid <= 1'b0;
    end else if (adv) begin
      meta2.valid <= meta1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta2.last <= meta1.last;
      sq_a       <= prod_a;
      sq_b       <= prod_b;
      sq_c       <= prod_c;
    end
  end

  // Stage 3: sum of squares, at most 3 * 2^(2W-2) so it fits RW bits
  logic [RW-1:0]  sum_sq;
  vm3_pkg::meta_t meta3;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta3.valid <= 1'b0;
    end else if (adv) begin
      meta3.valid <= meta2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta3.last <= meta2.last;
      sum_sq     <= sq_a + sq_b + sq_c;
    end
  end

  // Root pipeline; its last stage is the output register
  vm3_pkg::meta_t meta_out;
  logic [W-1:0]   root;

  vm3_sqrt_pipe #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .meta_in  (meta3),
    .radicand (sum_sq),
    .meta_out (meta_out),
    .root     (root)
  );

  assign out_valid      = meta_out.valid;
  assign last_point_out = meta_out.last;
  assign magnitude      = vm3_pkg::FIELD_W'(root);

  // Checks
  `VM3_ASSERT_NXT(a_skid_hold, skid_valid && !adv, skid_valid && $stable(skid_first))
  `VM3_ASSERT_NXT(a_skid_fill, out_valid && out_stall && in_valid && !in_stall, in_stall)
  `VM3_ASSERT_IMP(a_count_reset, $past(rst), component_count == vm3_pkg::COUNT_RESET)

endmodule

// ===== rtl/vm3_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit resolved per stage.
module vm3_sqrt_pipe #(
  parameter int SAMPLE_WIDTH = vm3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  vm3_pkg::meta_t            meta_in,
  input  logic [2*SAMPLE_WIDTH-1:0] radicand,
  output vm3_pkg::meta_t            meta_out,
  output logic [SAMPLE_WIDTH-1:0]   root
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int RW = 2 * SAMPLE_WIDTH;

  // Stage registers; index s holds the word after s result bits.
  logic [W-1:0]    root_q [1:W];
  vm3_pkg::meta_t  meta_q [1:W];
  logic [RW-1:0]   rem_q  [1:W-1];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;

    logic [RW-1:0]  rem_in;
    logic [W-1:0]   root_in;
    vm3_pkg::meta_t meta_st;
    logic [RW:0]    trial;
    logic           fits;
    logic [RW-1:0]  rem_next;
    logic [W-1:0]   root_next;

    if (s == 0) begin : g_head
      assign rem_in  = radicand;
      assign root_in = '0;
      assign meta_st = meta_in;
    end else begin : g_body
      assign rem_in  = rem_q[s];
      assign root_in = root_q[s];
      assign meta_st = meta_q[s];
    end

    // Try setting bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    always_comb begin
      trial     = ({1'b0, RW'(root_in)} << (B + 1)) + ((RW + 1)'(1) << (2 * B));
      fits      = ({1'b0, rem_in} >= trial);
      rem_next  = fits ? (rem_in - trial[RW-1:0]) : rem_in;
      root_next = root_in;
      root_next[B] = fits;
    end

    // Valid bits
    always_ff @(posedge clk) begin
      if (rst) begin
        meta_q[s+1].valid <= 1'b0;
      end else if (adv) begin
        meta_q[s+1].valid <= meta_st.valid;
      end
    end

    // Payload
    always_ff @(posedge clk) begin
      if (adv) begin
        meta_q[s+1].last <= meta_st.last;
        root_q[s+1]      <= root_next;
      end
    end

    if (s < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[s+1] <= rem_next;
        end
      end
    end
  end

  assign meta_out = meta_q[W];
  assign root     = root_q[W];

endmodule

// ===== dv/vector_magnitude_3d_top_tb.sv =====
`timescale 1ns / 1ps

module vector_magnitude_3d_top_tb;

  // Widths from the package
  localparam int FIELD_W = vm3_pkg::FIELD_W;
  localparam int DATA_W  = vm3_pkg::DATA_W;
  localparam int ADDR_W  = vm3_pkg::ADDR_W;
  localparam int COUNT_W = vm3_pkg::COUNT_W;

  // Count codes not named in the package
  localparam logic [COUNT_W-1:0] COUNT_ZERO = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;

  localparam logic [ADDR_W-1:0] COUNT_ADDR   = ADDR_W'(4 * vm3_pkg::REG_COMPONENT_COUNT);
  localparam int                PIPE_LATENCY = vm3_pkg::SAMPLE_WIDTH_DEF + 3;
  localparam int                RANDOM_PER_PHASE = 315;

  // Q16.16 handy values
  localparam logic [FIELD_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] Q_MOST  = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_LEAST = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] Q_ULP_N = 32'hFFFF_FFFF;

  typedef struct {
    logic [FIELD_W-1:0] length;
    logic               last;
  } length_word_t;

  // Scoreboard: predicts the length of each accepted point, checks results in order
  class length_board;
    logic [COUNT_W-1:0] active_count;
    length_word_t       expected_lengths[$];
    int                 errors;

    function new();
      active_count = vm3_pkg::COUNT_RESET;
      errors = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      active_count = value;
    endfunction

    // Exact square of the magnitude of a two's complement component
    function logic [63:0] square_of(logic [FIELD_W-1:0] c);
      logic [FIELD_W-1:0] mag;
      mag = c[FIELD_W-1] ? (~c + 1'b1) : c;
      return 64'(mag) * 64'(mag);
    endfunction

    // Floor of the Euclidean length; a count of zero acts as one
    function logic [FIELD_W-1:0] vector_length(logic [FIELD_W-1:0] c0,
                                               logic [FIELD_W-1:0] c1,
                                               logic [FIELD_W-1:0] c2);
      logic [63:0]        sum;
      logic [FIELD_W-1:0] root;
      logic [FIELD_W-1:0] trial;
      int                 b;
      sum = square_of(c0);
      if (active_count >= vm3_pkg::COUNT_TWO) sum += square_of(c1);
      if (active_count >= vm3_pkg::COUNT_THREE) sum += square_of(c2);
      // set root bits from the top down, keeping each that does not overshoot
      root = '0;
      for (b = FIELD_W - 1; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (64'(trial) * 64'(trial) <= sum) root = trial;
      end
      return root;
    endfunction

    function void note_point(logic [FIELD_W-1:0] c0, logic [FIELD_W-1:0] c1,
                             logic [FIELD_W-1:0] c2, logic last);
      length_word_t w;
      w.length = vector_length(c0, c1, c2);
      w.last   = last;
      expected_lengths = {expected_lengths, w};
    endfunction

    function void check_length(logic [FIELD_W-1:0] length, logic last);
      length_word_t w;
      if (expected_lengths.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: magnitude %h last %b", $time, length, last);
        return;
      end
      w = expected_lengths.pop_front();
      if (length !== w.length) begin
        errors++;
        $display("%0t: magnitude mismatch: expected %h, actual %h",
                 $time, w.length, length);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: last_point_out mismatch: expected %b, actual %b",
                 $time, w.last, last);
      end
    endfunction

    function int pending_count();
      return expected_lengths.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [FIELD_W-1:0]  first_component;
  logic signed [FIELD_W-1:0]  second_component;
  logic signed [FIELD_W-1:0]  third_component;
  logic                       last_point_in;
  logic                       out_valid;
  logic                       out_stall;
  logic [FIELD_W-1:0]         magnitude;
  logic                       last_point_out;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  length_board board;
  bit          quiet_in;
  bit          quiet_out;
  int          reg_errors;

  vector_magnitude_3d_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .first_component  (first_component),
    .second_component (second_component),
    .third_component  (third_component),
    .last_point_in    (last_point_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .magnitude        (magnitude),
    .last_point_out   (last_point_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Component value drawn from a mix of ranges
  function logic [FIELD_W-1:0] pick_component();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 255);
      5: begin
        case ($urandom_range(4))
          0: v = Q_LEAST;
          1: v = Q_MOST;
          2: v = Q_ULP_N;
          3: v = '0;
          default: v = 32'd1;
        endcase
      end
      6: v = $urandom_range(0, 2 * Q_ONE);
      default: v = FIELD_W'($signed($urandom) >>> $urandom_range(1, 30));
    endcase
    if ($urandom_range(1) && v != Q_LEAST) v = ~v + 1'b1;
    return v;
  endfunction

  // Result side stall pattern
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int hold;
      if (quiet_out) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        hold = pick_idle();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_length(magnitude, last_point_out);
  end

  // Drive one point and hold it until accepted
  task send_point(input logic [FIELD_W-1:0] c0, input logic [FIELD_W-1:0] c1,
                  input logic [FIELD_W-1:0] c2, input logic last);
    int gap;
    gap = quiet_in ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    first_component  <= c0;
    second_component <= c1;
    third_component  <= c2;
    last_point_in    <= last;
    do @(posedge clk); while (in_stall);
    board.note_point(c0, c1, c2, last);
  endtask

  task send_random_point();
    logic [FIELD_W-1:0] c0, c1, c2;
    int                 k;
    if ($urandom_range(9) == 0) begin
      // scaled Pythagorean sets give exact roots; a nudge tests just next to them
      k  = $urandom_range(1, 1 << 20);
      c0 = 3 * k;
      c1 = 4 * k;
      c2 = $urandom_range(1) ? 12 * k : 0;
      if ($urandom_range(1)) c0 = ~c0 + 1'b1;
      if ($urandom_range(1)) c2 = ~c2 + 1'b1;
      if ($urandom_range(2) == 0) c0 = c0 - 1'b1;
    end else begin
      c0 = pick_component();
      c1 = pick_component();
      c2 = pick_component();
    end
    send_point(c0, c1, c2, $urandom_range(7) == 0);
  endtask

  // Stop sending and wait until every expected word has come back
  task wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  task apb_write(input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task apb_read(output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= COUNT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task check_count_reg(input logic [COUNT_W-1:0] value);
    logic [DATA_W-1:0] data;
    apb_read(data);
    if (data[COUNT_W-1:0] !== value) begin
      reg_errors++;
      $display("%0t: component_count readback mismatch: expected %h, actual %h",
               $time, value, data[COUNT_W-1:0]);
    end
    @(posedge clk);
  endtask

  task set_component_count(input logic [COUNT_W-1:0] value);
    apb_write(DATA_W'(value));
    board.set_count(value);
    @(posedge clk);
    check_count_reg(value);
  endtask

  // Stimulus
  initial begin
    logic [COUNT_W-1:0] phase_counts[6];
    int                 p, n;
    phase_counts = '{vm3_pkg::COUNT_THREE, COUNT_ONE, vm3_pkg::COUNT_TWO,
                     COUNT_ZERO, vm3_pkg::COUNT_THREE, vm3_pkg::COUNT_TWO};
    board      = new();
    reg_errors = 0;
    quiet_in   = 1'b1;
    quiet_out  = 1'b1;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    first_component  <= '0;
    second_component <= '0;
    third_component  <= '0;
    last_point_in    <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_count_reg(vm3_pkg::COUNT_RESET);

    // one component: others are junk and must be ignored
    send_point(Q_LEAST, Q_MOST, Q_LEAST, 1'b1);
    send_point(Q_MOST, Q_LEAST, Q_MOST, 1'b0);
    send_point(Q_ULP_N, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    wait_drain();

    // count of zero acts as one
    set_component_count(COUNT_ZERO);
    send_point(~Q_ONE + 1'b1, Q_MOST, Q_MOST, 1'b0);
    send_point(Q_LEAST, Q_LEAST, Q_LEAST, 1'b1);
    wait_drain();

    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    set_component_count(vm3_pkg::COUNT_TWO);
    send_point(3 * Q_ONE, 4 * Q_ONE, Q_MOST, 1'b0);
    send_point(Q_LEAST, Q_LEAST, 32'd5, 1'b1);
    send_point(Q_MOST, Q_LEAST, '0, 1'b0);
    send_point(32'd1, Q_ULP_N, Q_LEAST, 1'b0);
    wait_drain();

    set_component_count(vm3_pkg::COUNT_THREE);
    send_point('0, '0, '0, 1'b0);
    send_point(Q_LEAST, Q_LEAST, Q_LEAST, 1'b1);
    send_point(Q_MOST, Q_MOST, Q_MOST, 1'b0);
    send_point(Q_MOST, Q_LEAST, Q_MOST, 1'b1);
    send_point(32'd1, 32'd1, 32'd1, 1'b0);
    send_point('0, '0, 32'd1, 1'b1);
    send_point(Q_ULP_N, Q_ULP_N, Q_ULP_N, 1'b0);
    send_point(2 * Q_ONE, ~(3 * Q_ONE) + 1'b1, 6 * Q_ONE, 1'b1);
    send_point(Q_ONE, '0, '0, 1'b0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 1'b1);
    wait_drain();

    // random phases over all counts
    for (p = 0; p < 6; p++) begin
      quiet_in  = (p == 1);
      quiet_out = (p == 1);
      set_component_count(phase_counts[p]);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 0 && n == RANDOM_PER_PHASE / 2) wait_drain();
        send_random_point();
      end
      wait_drain();
    end

    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && reg_errors == 0 && board.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== vector_magnitude_3d_top.f =====
+incdir+rtl
rtl/vm3_pkg.sv
rtl/vm3_sqrt_pipe.sv
rtl/vector_magnitude_3d_top.sv
dv/vector_magnitude_3d_top_tb.sv
